@@ rtl/core/rdsm_pkg.sv @@
package rdsm_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_TEXT   = 2'd2;
    localparam logic [1:0] REQ_END    = 2'd3;

    // Pattern bytes with a special meaning.
    localparam logic [7:0] DOT_BYTE  = 8'h2E;
    localparam logic [7:0] STAR_BYTE = 8'h2A;

    // One input transaction.
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_value;
    } t_req;

    // One result transaction.
    typedef struct packed {
        logic matched;
        logic overflow;
    } t_result;

    // What one pattern cell reports to the chain for the current text byte.
    typedef struct packed {
        logic star;   // this position starts a starred token
        logic keep;   // the byte is consumed by the star, stay here
        logic fwd;    // the byte is consumed by a literal, move one on
    } t_cell_stat;

endpackage

@@ rtl/core/regex_dot_star_matcher.sv @@
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_req)
// out     | output    | o_out_valid / i_out_stall  | o_out_data (t_result)
//
// The requests are clear, append, text byte or end of text.
// A text byte moves the whole active set through the cell chain in one step;
// star runs are closed by one carry chain per parity lane of positions.
// End of text loads the result register at its accepting edge; the result is
// offered in the next cycle.
// The input stalls only while a result waits and the output is stalled.
// Reset (synchronous, active low) empties the pattern and the result register.
module regex_dot_star_matcher
    import rdsm_pkg::*;
#(
    parameter int MAX_PATTERN = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_req    i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int NUM_E = MAX_PATTERN / 2 + 1;
    localparam int NUM_O = (MAX_PATTERN + 1) / 2;

    logic [LEN_W-1:0]     r_len;
    logic                 r_ovf;
    logic [MAX_PATTERN:0] r_act;
    logic                 r_out_valid;
    t_result              r_out;

    logic                   in_acc;
    logic                   app_wr;
    logic [MAX_PATTERN-1:0] cell_wr;
    logic [7:0]             cell_byte [MAX_PATTERN];
    t_cell_stat             cell_stat [MAX_PATTERN];
    logic [MAX_PATTERN:0]   closed;
    logic [MAX_PATTERN:0]   n_act;
    logic [NUM_E-1:0]       e_set, e_prop, e_closed;
    logic [NUM_O-1:0]       o_set, o_prop, o_closed;
    t_result                n_out;

    // Handshake: new work is held off only while a result cannot leave.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    // An append writes the cell at the current length unless the store is full.
    assign app_wr = in_acc && (i_in_data.req_type == REQ_APPEND)
                    && (r_len != LEN_W'(MAX_PATTERN));

    // The chain of pattern cells.
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic [7:0] nb_byte;

        assign cell_wr[j] = app_wr && (r_len == LEN_W'(j));

        if (j + 1 < MAX_PATTERN) begin : g_mid
            assign nb_byte = cell_byte[j + 1];
        end else begin : g_last
            assign nb_byte = 8'h00;
        end

        rdsm_cell #(
            .IDX   (j),
            .LEN_W (LEN_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_wr        (cell_wr[j]),
            .i_char      (i_in_data.char_value),
            .i_len       (r_len),
            .i_next_byte (nb_byte),
            .i_active    (closed[j]),
            .o_byte      (cell_byte[j]),
            .o_stat      (cell_stat[j])
        );
    end

    // Split the stored set into even and odd lanes for the star closure.
    for (genvar k = 0; k < NUM_E; k++) begin : g_even
        assign e_set[k] = r_act[2 * k];
        if (2 * k < MAX_PATTERN) begin : g_p
            assign e_prop[k] = cell_stat[2 * k].star;
        end else begin : g_np
            assign e_prop[k] = 1'b0;
        end
    end

    for (genvar k = 0; k < NUM_O; k++) begin : g_odd
        assign o_set[k] = r_act[2 * k + 1];
        if (2 * k + 1 < MAX_PATTERN) begin : g_p
            assign o_prop[k] = cell_stat[2 * k + 1].star;
        end else begin : g_np
            assign o_prop[k] = 1'b0;
        end
    end

    rdsm_close #(.WIDTH(NUM_E)) u_close_even (
        .i_set    (e_set),
        .i_prop   (e_prop),
        .o_closed (e_closed)
    );

    rdsm_close #(.WIDTH(NUM_O)) u_close_odd (
        .i_set    (o_set),
        .i_prop   (o_prop),
        .o_closed (o_closed)
    );

    // Merge the lanes back, and form the next set from the cells' hits.
    for (genvar j = 0; j <= MAX_PATTERN; j++) begin : g_merge
        if (j % 2 == 0) begin : g_e
            assign closed[j] = e_closed[j / 2];
        end else begin : g_o
            assign closed[j] = o_closed[j / 2];
        end

        if (j == 0) begin : g_first
            assign n_act[j] = cell_stat[j].keep;
        end else if (j == MAX_PATTERN) begin : g_top
            assign n_act[j] = cell_stat[j - 1].fwd;
        end else begin : g_body
            assign n_act[j] = cell_stat[j].keep || cell_stat[j - 1].fwd;
        end
    end

    // Result of an end of text.
    assign n_out.matched  = closed[r_len] && !r_ovf;
    assign n_out.overflow = r_ovf;

    // Pattern length, overflow flag and active set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ovf <= 1'b0;
            r_act <= (MAX_PATTERN + 1)'(1);
        end else if (in_acc) begin
            unique case (i_in_data.req_type)
                REQ_CLEAR: begin
                    r_len <= '0;
                    r_ovf <= 1'b0;
                    r_act <= (MAX_PATTERN + 1)'(1);
                end
                REQ_APPEND: begin
                    if (r_len == LEN_W'(MAX_PATTERN)) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_len <= r_len + LEN_W'(1);
                    end
                    r_act <= (MAX_PATTERN + 1)'(1);
                end
                REQ_TEXT: begin
                    r_act <= n_act;
                end
                REQ_END: begin
                    r_act <= (MAX_PATTERN + 1)'(1);
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && (i_in_data.req_type == REQ_END)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.req_type == REQ_END)) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/core/rdsm_cell.sv @@
module rdsm_cell
    import rdsm_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int LEN_W = 7
) (
    input  logic             i_clk,
    input  logic             i_wr,
    input  logic [7:0]       i_char,
    input  logic [LEN_W-1:0] i_len,
    input  logic [7:0]       i_next_byte,
    input  logic             i_active,
    output logic [7:0]       o_byte,
    output t_cell_stat       o_stat
);

    logic [7:0] r_byte;
    logic       in_use;
    logic       next_in_use;
    logic       hit;

    // The pattern byte of this position, loaded when the append lands here.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_byte <= i_char;
        end
    end

    assign o_byte = r_byte;

    // Only positions below the current length take part.
    assign in_use      = i_len > LEN_W'(IDX);
    assign next_in_use = i_len > LEN_W'(IDX + 1);

    // The neighbor's byte tells whether this position is starred.
    assign o_stat.star = next_in_use && (i_next_byte == STAR_BYTE);

    assign hit = in_use && i_active && ((r_byte == DOT_BYTE) || (r_byte == i_char));

    assign o_stat.keep = hit && o_stat.star;
    assign o_stat.fwd  = hit && !o_stat.star;

endmodule

@@ rtl/core/rdsm_close.sv @@
module rdsm_close #(
    parameter int WIDTH = 33
) (
    input  logic [WIDTH-1:0] i_set,
    input  logic [WIDTH-1:0] i_prop,
    output logic [WIDTH-1:0] o_closed
);

    logic [WIDTH-1:0] gen;
    logic [WIDTH-1:0] sum;
    logic [WIDTH-1:0] carry;

    // Closure along one lane is a carry chain: an active starred position
    // generates, a starred position that is reached only by carry propagates.
    // The adder's carries give the reach of every star run in one pass.
    assign gen      = i_set & i_prop;
    assign sum      = i_prop + gen;
    assign carry    = sum ^ i_prop ^ gen;
    assign o_closed = i_set | carry;

endmodule

@@ rtl/core/rdsm_checker.sv @@
module rdsm_checker
    import rdsm_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    o_in_stall,
    input t_req    i_in_data,
    input logic    o_out_valid,
    input logic    i_out_stall,
    input t_result o_out_data
);

    logic end_acc;

    assign end_acc = i_in_valid && !o_in_stall && (i_in_data.req_type == REQ_END);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // An overflowed pattern never reports a match.
    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.matched && o_out_data.overflow))
        else $error("match reported with overflow");

    // An accepted end of text always presents a result next cycle.
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_acc |=> o_out_valid)
        else $error("end of text produced no result");

    // A fresh result only follows an accepted end of text.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !($past(o_out_valid) && $past(i_out_stall)))
            |-> $past(end_acc))
        else $error("result without end of text");

    // A clear followed at once by end of text matches the empty text.
    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.req_type == REQ_CLEAR)) ##1 end_acc
            |=> o_out_data.matched)
        else $error("empty pattern failed on empty text");

endmodule

bind regex_dot_star_matcher rdsm_checker u_rdsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

@@ bench/regex_dot_star_matcher_tb.sv @@
module regex_dot_star_matcher_tb;
    import rdsm_pkg::*;

    localparam int MAX_PATTERN = 64;
    localparam int ITEMS       = 750;
    localparam int LIMIT       = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 16;

    // Ordinary bytes that the stimulus favors so that matches happen often.
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;

    // Tracks the pattern and the set of reachable pattern positions, and
    // keeps the verdicts that are owed for end-of-text transactions.
    class match_predictor;
        logic [7:0]           pat_bytes [MAX_PATTERN];
        int unsigned          pat_len;
        logic [MAX_PATTERN:0] live;
        bit                   over;
        t_result              verdicts [$];
        int unsigned          errors;

        function new();
            pat_len = 0;
            over    = 1'b0;
            errors  = 0;
            restart();
        endfunction

        function void restart();
            live    = '0;
            live[0] = 1'b1;
        endfunction

        // Position j opens a starred token when the next byte is a star.
        function bit starred(int unsigned j);
            return (j + 1 < pat_len) && (pat_bytes[j + 1] == STAR_BYTE);
        endfunction

        // A reachable starred token also makes the position after it reachable.
        function logic [MAX_PATTERN:0] closed(logic [MAX_PATTERN:0] s);
            for (int unsigned j = 0; j < pat_len; j++) begin
                if (s[j] && starred(j)) begin
                    s[j + 2] = 1'b1;
                end
            end
            return s;
        endfunction

        function void consume(logic [7:0] c);
            logic [MAX_PATTERN:0] cur;
            logic [MAX_PATTERN:0] nxt;
            cur = closed(live);
            nxt = '0;
            for (int unsigned j = 0; j < pat_len; j++) begin
                if (cur[j] && (pat_bytes[j] == DOT_BYTE || pat_bytes[j] == c)) begin
                    if (starred(j)) begin
                        nxt[j] = 1'b1;
                    end else begin
                        nxt[j + 1] = 1'b1;
                    end
                end
            end
            live = closed(nxt);
        endfunction

        // Applies one accepted input transaction.
        function void note_request(t_req r);
            t_result v;
            case (r.req_type)
                REQ_CLEAR: begin
                    pat_len = 0;
                    over    = 1'b0;
                    restart();
                end
                REQ_APPEND: begin
                    if (pat_len >= MAX_PATTERN) begin
                        over = 1'b1;
                    end else begin
                        pat_bytes[pat_len] = r.char_value;
                        pat_len++;
                    end
                    restart();
                end
                REQ_TEXT: begin
                    consume(r.char_value);
                end
                default: begin
                    live      = closed(live);
                    v.matched  = live[pat_len] && !over;
                    v.overflow = over;
                    verdicts.push_back(v);
                    restart();
                end
            endcase
        endfunction

        // Compares one accepted result transaction with the oldest verdict.
        function void check_result(t_result got);
            t_result want;
            if (verdicts.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result: matched=%0b overflow=%0b",
                             got.matched, got.overflow);
                end
            end else begin
                want = verdicts.pop_front();
                if (got.matched !== want.matched || got.overflow !== want.overflow) begin
                    errors++;
                    if (errors <= 10) begin
                        $display({"result mismatch: expected matched=%0b overflow=%0b, ",
                                  "got matched=%0b overflow=%0b"},
                                 want.matched, want.overflow, got.matched, got.overflow);
                    end
                end
            end
        endfunction

        function int outstanding();
            return verdicts.size();
        endfunction
    endclass

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_in_valid = 1'b0;
    logic    o_in_stall;
    t_req    i_in_data = '0;
    logic    o_out_valid;
    logic    i_out_stall = 1'b0;
    t_result o_out_data;

    match_predictor sb = new();

    int unsigned sent_count = 0;
    int unsigned cycles = 0;
    int unsigned stall_left = 0;
    int unsigned calm_left = 0;
    bit          quiet = 1'b0;
    logic        hold_off = 1'b0;

    regex_dot_star_matcher #(
        .MAX_PATTERN(MAX_PATTERN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run limit: a hung block ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("regex_dot_star_matcher test failed");
            $finish;
        end
    end

    function automatic logic [7:0] rand_text_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4) return CH_A;
        if (r < 7) return CH_B;
        if (r == 7) return STAR_BYTE;
        if (r == 8) return DOT_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_pattern_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3) return CH_A;
        if (r < 5) return CH_B;
        if (r < 7) return DOT_BYTE;
        if (r < 9) return STAR_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offers one input transaction after a random gap and waits until it is taken.
    task automatic send_req(input logic [1:0] kind, input logic [7:0] ch);
        int unsigned gap;
        int unsigned r;
        t_req        req;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            gap = 0;
        end else if (r < 90) begin
            gap = $urandom_range(1, 3);
        end else if (r < 97) begin
            gap = $urandom_range(4, 12);
        end else begin
            gap = $urandom_range(20, 40);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.req_type   = kind;
        req.char_value = ch;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(req);
        sent_count++;
    endtask

    task automatic build_pattern(input int unsigned n);
        repeat (n) send_req(REQ_APPEND, rand_pattern_byte());
    endtask

    // Sends one text and its end. A derived text walks the stored tokens, so it
    // usually matches; sometimes one byte is spoiled to give a near miss.
    task automatic run_text(input bit derived);
        logic [7:0]  txt [$];
        int unsigned j;
        int unsigned n;
        logic [7:0]  b;
        if (derived) begin
            j = 0;
            while (j < sb.pat_len) begin
                if (j + 1 < sb.pat_len && sb.pat_bytes[j + 1] == STAR_BYTE) begin
                    n = $urandom_range(0, 3);
                    repeat (n) begin
                        b = (sb.pat_bytes[j] == DOT_BYTE) ? rand_text_byte() : sb.pat_bytes[j];
                        txt.push_back(b);
                    end
                    j += 2;
                end else begin
                    b = (sb.pat_bytes[j] == DOT_BYTE) ? rand_text_byte() : sb.pat_bytes[j];
                    txt.push_back(b);
                    j++;
                end
            end
            if (txt.size() != 0 && $urandom_range(0, 3) == 0) begin
                txt[$urandom_range(0, txt.size() - 1)] = rand_text_byte();
            end
        end else begin
            n = $urandom_range(0, 8);
            repeat (n) txt.push_back(rand_text_byte());
        end
        foreach (txt[k]) send_req(REQ_TEXT, txt[k]);
        send_req(REQ_END, 8'($urandom_range(0, 255)));
    endtask

    // Result side: check each accepted transaction, then choose the next stall.
    always @(posedge i_clk) begin
        int unsigned pick;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_data);
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
        end else if (calm_left != 0) begin
            calm_left = calm_left - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                calm_left = $urandom_range(30, 150);
            end else if (pick < 55) begin
                stall_left = 0;
            end else if (pick < 88) begin
                stall_left = $urandom_range(1, 3);
            end else if (pick < 97) begin
                stall_left = $urandom_range(4, 12);
            end else begin
                stall_left = $urandom_range(20, 50);
            end
        end
        i_out_stall <= hold_off || (stall_left != 0);
    end

    // One long hold-off on the result side while requests keep coming, so the
    // block fills up and stalls its input.
    initial begin
        while (sent_count < 150) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        int unsigned pick;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pattern, star tokens, byte extremes, literal star,
        // append restarting the text, and end of text restarting the set.
        send_req(REQ_END, 8'h00);
        send_req(REQ_TEXT, CH_A);
        send_req(REQ_END, 8'h00);
        send_req(REQ_APPEND, DOT_BYTE);
        send_req(REQ_APPEND, STAR_BYTE);
        send_req(REQ_END, 8'h00);
        send_req(REQ_TEXT, 8'h00);
        send_req(REQ_TEXT, 8'hFF);
        send_req(REQ_END, 8'h00);
        send_req(REQ_CLEAR, 8'h00);
        send_req(REQ_APPEND, 8'hFF);
        send_req(REQ_TEXT, 8'hFF);
        send_req(REQ_APPEND, STAR_BYTE);
        send_req(REQ_TEXT, 8'hFF);
        send_req(REQ_TEXT, 8'hFF);
        send_req(REQ_END, 8'h00);
        send_req(REQ_CLEAR, 8'h00);
        send_req(REQ_APPEND, STAR_BYTE);
        send_req(REQ_TEXT, STAR_BYTE);
        send_req(REQ_END, 8'h00);
        send_req(REQ_CLEAR, 8'hFF);
        send_req(REQ_TEXT, 8'h00);
        send_req(REQ_END, 8'hFF);
        send_req(REQ_END, 8'h00);

        // Random: mostly short patterns with texts that walk them, some full or
        // overflowing patterns, and some loose transactions of any kind.
        while (sent_count < ITEMS) begin
            quiet = ($urandom_range(0, 4) == 0);
            pick  = $urandom_range(0, 99);
            if (pick < 7) begin
                send_req(REQ_CLEAR, 8'($urandom_range(0, 255)));
                build_pattern(MAX_PATTERN);
                if ($urandom_range(0, 1) == 1) begin
                    build_pattern($urandom_range(1, 3));
                end
                repeat ($urandom_range(1, 2)) run_text($urandom_range(0, 3) != 0);
            end else if (pick < 90) begin
                if ($urandom_range(0, 4) != 0) begin
                    send_req(REQ_CLEAR, 8'($urandom_range(0, 255)));
                end
                build_pattern($urandom_range(0, 8));
                repeat ($urandom_range(1, 4)) run_text($urandom_range(0, 9) < 6);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
            end
        end
        i_in_valid <= 1'b0;

        // Drain the owed results, then keep watching for stray ones.
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("regex_dot_star_matcher test passed");
        end else begin
            $display("regex_dot_star_matcher test failed");
        end
        $finish;
    end

endmodule
